// ----- rtl/packed_10bit_five_channel_deinterleaver_assert.svh -----
// Assertion macros for the 10-bit packed sample deinterleaver.
// Included by the top level; no other dependencies.
`ifndef PACKED_10BIT_FIVE_CHANNEL_DEINTERLEAVER_ASSERT_SVH
`define PACKED_10BIT_FIVE_CHANNEL_DEINTERLEAVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define P10D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("p10deint: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define P10D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("p10deint: next-cycle check failed");

`endif

// ----- rtl/p10deint_pkg.sv -----
// Shared constants and widths for the 10-bit packed sample deinterleaver.
// No dependencies.
package p10deint_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_PIXELS_PER_LINE  = 2048;
    localparam int DEF_HEADER_BYTES     = 14;
    localparam int DEF_FIRST_PIXEL_WORD = 55;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int WORD_W    = 10;
    localparam int GAIN_W    = 7;
    localparam int PIXEL_W   = 16;
    localparam int CHAN_W    = 3;
    localparam int COLUMN_W  = 11;
    localparam int LINE_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int PHASE_W   = 3;

    localparam int NUM_CHANNELS = 5;
    localparam int GROUP_BYTES  = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 1'b1;

    // Configuration reset values
    localparam logic [GAIN_W-1:0] GAIN_RESET       = 7'd60;
    localparam logic [LEN_W-1:0]  MIN_LENGTH_RESET = 16'd12960;

endpackage

// ----- rtl/p10deint_scale.sv -----
// Scales one 10-bit sample by the gain, saturating to the pixel width.
// Depends on p10deint_pkg.
module p10deint_scale
    import p10deint_pkg::*;
(
    input  logic [WORD_W-1:0]  word,
    input  logic [GAIN_W-1:0]  gain,
    output logic [PIXEL_W-1:0] pixel
);

    localparam int PROD_W = WORD_W + GAIN_W;

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(word) * PROD_W'(gain);

    // Clamp at full scale
    assign pixel = (prod[PROD_W-1:PIXEL_W] != '0) ? {PIXEL_W{1'b1}} : prod[PIXEL_W-1:0];

endmodule

// ----- rtl/packed_10bit_five_channel_deinterleaver.sv -----
// Top level of the 10-bit packed sample deinterleaver.
// Depends on p10deint_pkg, p10deint_scale and the assertion macro header.
//
// Takes a packet payload one byte per transaction on the s_ channel, the first
// byte flagged by s_first together with the payload length. Packets shorter
// than min_length are dropped whole. In an accepted packet the header bytes
// are skipped, each group of five bytes is unpacked into four 10-bit words,
// MSB first, the leading words up to FIRST_PIXEL_WORD are discarded, and the
// rest are dealt round-robin over five channels. Each pixel leaves on the m_
// channel as word times gain (saturated to 16 bits) with its channel, column
// and line number; line_end marks channel 4 of the last column, after which
// the packet is closed and the line counter advances. Throughput is one
// byte per clock cycle, sustained: the unpacking, scaling and counter update
// for a byte sit between the state registers and the output register, so a
// byte's result is registered in the cycle after its transaction. The output
// register holds a pending pixel while the input keeps flowing, as long as
// the sink takes pixels when they are offered. Configuration (gain at index
// 0, min_length at index 1) must be written through cfg_wr_en, cfg_index and
// cfg_wdata by the user only while the block is idle; the block does not enforce this.
`include "packed_10bit_five_channel_deinterleaver_assert.svh"

module packed_10bit_five_channel_deinterleaver
    import p10deint_pkg::*;
#(
    parameter int PIXELS_PER_LINE  = DEF_PIXELS_PER_LINE,
    parameter int HEADER_BYTES     = DEF_HEADER_BYTES,
    parameter int FIRST_PIXEL_WORD = DEF_FIRST_PIXEL_WORD
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_data_byte,
    input  logic                 s_first,
    input  logic [LEN_W-1:0]     s_payload_length,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PIXEL_W-1:0]   m_pixel,
    output logic [CHAN_W-1:0]    m_channel,
    output logic [COLUMN_W-1:0]  m_column,
    output logic [LINE_W-1:0]    m_line,
    output logic                 m_line_end
);

    // Counter widths follow the parameters
    localparam int HDR_W  = (HEADER_BYTES > 0) ? $clog2(HEADER_BYTES + 1) : 1;
    localparam int WIDX_W = (FIRST_PIXEL_WORD > 0) ? $clog2(FIRST_PIXEL_WORD + 1) : 1;
    localparam int COL_W  = (PIXELS_PER_LINE > 1) ? $clog2(PIXELS_PER_LINE) : 1;

    localparam logic [HDR_W-1:0]   HDR_LAST   = HDR_W'(HEADER_BYTES);
    localparam logic [WIDX_W-1:0]  WIDX_LAST  = WIDX_W'(FIRST_PIXEL_WORD);
    localparam logic [COL_W-1:0]   COL_LAST   = COL_W'(PIXELS_PER_LINE - 1);
    localparam logic [CHAN_W-1:0]  CHAN_LAST  = CHAN_W'(NUM_CHANNELS - 1);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(GROUP_BYTES - 1);

    // Configuration registers
    logic [GAIN_W-1:0] gain_reg;
    logic [LEN_W-1:0]  min_length_reg;

    // Unpacking state
    logic [HDR_W-1:0]   byte_pos_reg,  byte_pos_next;
    logic [PHASE_W-1:0] phase_reg,     phase_next;
    logic [BYTE_W-1:0]  held_reg,      held_next;
    logic [WIDX_W-1:0]  word_idx_reg,  word_idx_next;
    logic [CHAN_W-1:0]  chan_reg,      chan_next;
    logic [COL_W-1:0]   col_reg,       col_next;
    logic [LINE_W-1:0]  line_reg,      line_next;
    logic               packet_ok_reg, packet_ok_next;

    // Output register
    logic                m_valid_reg;
    logic [PIXEL_W-1:0]  m_pixel_reg;
    logic [CHAN_W-1:0]   m_channel_reg;
    logic [COLUMN_W-1:0] m_column_reg;
    logic [LINE_W-1:0]   m_line_reg;
    logic                m_line_end_reg;

    // Per-byte working values
    logic [HDR_W-1:0]   byte_pos_eff;
    logic [PHASE_W-1:0] phase_eff;
    logic [BYTE_W-1:0]  held_eff;
    logic [WIDX_W-1:0]  word_idx_eff;
    logic [CHAN_W-1:0]  chan_eff;
    logic [COL_W-1:0]   col_eff;
    logic               ok_eff;
    logic [WORD_W-1:0]  word;
    logic               emit;
    logic               last;
    logic               accept;
    logic               out_load;
    logic [PIXEL_W-1:0] pixel;
    logic [COL_W+COLUMN_W-1:0] col_wide;

    // Take a byte whenever the output register is empty or being drained
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign out_load = accept && emit;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg       <= GAIN_RESET;
            min_length_reg <= MIN_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GAIN:       gain_reg       <= cfg_wdata[GAIN_W-1:0];
                CFG_MIN_LENGTH: min_length_reg <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack one byte: a first byte restarts the packet before it is itself used
    always_comb begin
        if (s_first) begin
            byte_pos_eff = '0;
            phase_eff    = '0;
            held_eff     = '0;
            word_idx_eff = '0;
            chan_eff     = '0;
            col_eff      = '0;
            ok_eff       = (s_payload_length >= min_length_reg);
        end else begin
            byte_pos_eff = byte_pos_reg;
            phase_eff    = phase_reg;
            held_eff     = held_reg;
            word_idx_eff = word_idx_reg;
            chan_eff     = chan_reg;
            col_eff      = col_reg;
            ok_eff       = packet_ok_reg;
        end

        // MSB-first extraction of the 10-bit word completed by this byte
        case (phase_eff)
            3'd1:    word = {held_eff, s_data_byte[7:6]};
            3'd2:    word = {held_eff[5:0], s_data_byte[7:4]};
            3'd3:    word = {held_eff[3:0], s_data_byte[7:2]};
            3'd4:    word = {held_eff[1:0], s_data_byte};
            default: word = '0;
        endcase

        byte_pos_next  = byte_pos_eff;
        phase_next     = phase_eff;
        held_next      = held_eff;
        word_idx_next  = word_idx_eff;
        chan_next      = chan_eff;
        col_next       = col_eff;
        line_next      = line_reg;
        packet_ok_next = ok_eff;
        emit           = 1'b0;
        last           = (chan_eff == CHAN_LAST) && (col_eff == COL_LAST);

        if (ok_eff) begin
            if (byte_pos_eff < HDR_LAST) begin
                // Skip header
                byte_pos_next = byte_pos_eff + 1'b1;
            end else begin
                phase_next = (phase_eff >= PHASE_LAST) ? '0 : phase_eff + 1'b1;
                held_next  = s_data_byte;
                if (phase_eff != '0) begin
                    if (word_idx_eff < WIDX_LAST) begin
                        // Drop leading words
                        word_idx_next = word_idx_eff + 1'b1;
                    end else begin
                        emit = 1'b1;
                        if (last) begin
                            line_next      = line_reg + 1'b1;
                            packet_ok_next = 1'b0;
                        end else if (chan_eff >= CHAN_LAST) begin
                            chan_next = '0;
                            col_next  = col_eff + 1'b1;
                        end else begin
                            chan_next = chan_eff + 1'b1;
                        end
                    end
                end
            end
        end
    end

    p10deint_scale u_scale (
        .word  (word),
        .gain  (gain_reg),
        .pixel (pixel)
    );

    // Column field carries the low bits of the column counter
    assign col_wide = {{COLUMN_W{1'b0}}, col_eff};

    // Advance state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg  <= '0;
            phase_reg     <= '0;
            held_reg      <= '0;
            word_idx_reg  <= '0;
            chan_reg      <= '0;
            col_reg       <= '0;
            line_reg      <= '0;
            packet_ok_reg <= 1'b0;
        end else if (accept) begin
            byte_pos_reg  <= byte_pos_next;
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            word_idx_reg  <= word_idx_next;
            chan_reg      <= chan_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
            packet_ok_reg <= packet_ok_next;
        end
    end

    // Output valid: set on a new pixel, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload: hold until replaced
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pixel_reg    <= pixel;
            m_channel_reg  <= chan_eff;
            m_column_reg   <= col_wide[COLUMN_W-1:0];
            m_line_reg     <= line_reg;
            m_line_end_reg <= last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_pixel    = m_pixel_reg;
    assign m_channel  = m_channel_reg;
    assign m_column   = m_column_reg;
    assign m_line     = m_line_reg;
    assign m_line_end = m_line_end_reg;

    // Checks
    `P10D_ASSERT_NOW(a_line_end_chan, aclk, aresetn, m_valid_reg && m_line_end_reg, m_channel_reg == CHAN_LAST)
    `P10D_ASSERT_NOW(a_chan_range, aclk, aresetn, 1'b1, chan_reg <= CHAN_LAST)
    `P10D_ASSERT_NEXT(a_close_on_last, aclk, aresetn, out_load && last, !packet_ok_reg)
    `P10D_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid_reg, s_ready)

endmodule
